@@ hw/rtl/planar_arm_forward_kinematics_top_defines.svh @@
// assertion macros for the planar arm forward kinematics block
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PAFK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pafk same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define PAFK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pafk next-cycle check failed");

`endif

@@ hw/rtl/pafk_pkg.sv @@
// shared types, constants and the arctangent table of the arm kinematics block
package pafk_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int LINK_W  = 15;
  localparam int GAIN_W  = 30;
  localparam int ANGLE_W = 16;
  localparam int POS_W   = 16;
  localparam int TURN_W  = 32;
  localparam int Z_W     = TURN_W + 2;
  localparam int XY_W    = 33;
  localparam int ROT_W   = XY_W + 1 - 16;
  localparam int ACC_W   = 24;
  localparam int TAB_W   = 5;
  localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int DROP    = TURN_W - ANGLE_BITS;

  // queue depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [LINK_W-1:0] LINK_RESET = LINK_W'(10923);
  localparam logic [GAIN_W-1:0] GAIN_Q30   = GAIN_W'(652032874);

  localparam logic [TURN_W-1:0] ANGLE_MASK = ~(TURN_W'((64'd1 << DROP) - 64'd1));
  localparam logic [TURN_W:0]   ROUND_HALF = (TURN_W + 1)'((64'd1 << DROP) >> 1);

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TURN_W-1:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic [TURN_W-1:0] angle;
    logic              flip;
    logic              last;
  } joint_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_ROTATE,
    BACK_ACCUM
  } back_state_t;

  // table entry rounded to the angle resolution
  function automatic logic [TURN_W-1:0] atan_step(input logic [TAB_W-1:0] idx);
    logic [TURN_W:0] t;
    t = {1'b0, ATAN_TURNS[idx]} + ROUND_HALF;
    t = (t >> DROP) << DROP;
    return t[TURN_W-1:0];
  endfunction

endpackage

@@ hw/rtl/pafk_front.sv @@
// front end: takes joint requests, keeps the running angle sum and folds the angle
module pafk_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pafk_pkg::ANGLE_W-1:0] joint_angle,
  input  logic                                last_joint,
  input  pafk_pkg::queue_status_t             q_status,
  output logic                                push,
  output pafk_pkg::joint_req_t                push_req
);
  import pafk_pkg::*;

  logic [ANGLE_W-1:0] angle_sum;
  logic [ANGLE_W-1:0] angle_sum_next;
  logic [TURN_W-1:0]  turn;
  logic               flip;

  assign in_ready       = !q_status.full;
  assign push           = in_valid && in_ready;
  assign angle_sum_next = angle_sum + ANGLE_W'(joint_angle);

  // angle in 2^-32 turn, cut to the working resolution
  assign turn = {angle_sum_next, {(TURN_W - ANGLE_W){1'b0}}} & ANGLE_MASK;

  // beyond a quarter turn: turn by half a turn, negate later
  assign flip = turn[TURN_W-1] ^ turn[TURN_W-2];

  always_comb begin
    push_req.angle = {turn[TURN_W-1] ^ flip, turn[TURN_W-2:0]};
    push_req.flip  = flip;
    push_req.last  = last_joint;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_sum <= '0;
    end else if (push) begin
      angle_sum <= last_joint ? '0 : angle_sum_next;
    end
  end

endmodule

@@ hw/rtl/pafk_queue.sv @@
// short request queue between the front end and the rotation unit
module pafk_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pafk_pkg::joint_req_t    push_req,
  input  logic                    pop,
  output pafk_pkg::joint_req_t    head,
  output pafk_pkg::queue_status_t status
);
  import pafk_pkg::*;

  joint_req_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/pafk_back.sv @@
// back end: iterative rotation, position accumulation and output register
module pafk_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [pafk_pkg::LINK_W-1:0]        link_len,
  input  logic                               q_empty,
  input  pafk_pkg::joint_req_t               head,
  output logic                               pop,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pafk_pkg::POS_W-1:0]  pos_x,
  output logic signed [pafk_pkg::POS_W-1:0]  pos_y
);
  import pafk_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;
  logic                    flip;
  logic                    last;
  logic [STEP_W-1:0]       iter;
  logic signed [ACC_W-1:0] x_accum;
  logic signed [ACC_W-1:0] y_accum;

  logic                    do_step;
  logic                    do_accum;
  logic                    out_blocked;

  logic [LINK_W+GAIN_W-1:0] gain_prod;
  logic signed [XY_W-1:0]   x_start;
  logic signed [XY_W-1:0]   dx;
  logic signed [XY_W-1:0]   dy;
  logic signed [Z_W-1:0]    z_step;
  logic signed [XY_W-1:0]   xf;
  logic signed [XY_W-1:0]   yf;
  logic signed [XY_W:0]     xr;
  logic signed [XY_W:0]     yr;
  logic signed [ACC_W-1:0]  x_accum_next;
  logic signed [ACC_W-1:0]  y_accum_next;

  function automatic logic signed [ACC_W-1:0] sat_acc(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ROT_W-1:0] delta
  );
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + (ACC_W + 1)'(delta);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] acc);
    if (acc > ACC_W'($signed({1'b0, {(POS_W - 1){1'b1}}}))) begin
      return {1'b0, {(POS_W - 1){1'b1}}};
    end else if (acc < ACC_W'($signed({1'b1, {(POS_W - 1){1'b0}}}))) begin
      return {1'b1, {(POS_W - 1){1'b0}}};
    end
    return acc[POS_W-1:0];
  endfunction

  // start vector is link length times the cordic gain, Q0.30
  assign gain_prod = (LINK_W + GAIN_W)'(link_len) * (LINK_W + GAIN_W)'(GAIN_Q30);
  assign x_start   = XY_W'(gain_prod[LINK_W+GAIN_W-1:LINK_W]);

  assign dx     = y >>> iter;
  assign dy     = x >>> iter;
  assign z_step = Z_W'(atan_step(TAB_W'(iter)));

  // undo the half turn, round to Q1.14
  assign xf = flip ? -x : x;
  assign yf = flip ? -y : y;
  assign xr = {xf[XY_W-1], xf} + (XY_W + 1)'(32768);
  assign yr = {yf[XY_W-1], yf} + (XY_W + 1)'(32768);

  assign x_accum_next = sat_acc(x_accum, xr[XY_W:16]);
  assign y_accum_next = sat_acc(y_accum, yr[XY_W:16]);

  assign out_blocked = last && out_valid && !out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BACK_IDLE: begin
        if (!q_empty) begin
          state_next = BACK_ROTATE;
        end
      end
      BACK_ROTATE: begin
        if (iter == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = BACK_ACCUM;
        end
      end
      BACK_ACCUM: begin
        if (!out_blocked) begin
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    do_step  = 1'b0;
    do_accum = 1'b0;
    busy     = 1'b1;
    unique case (state)
      BACK_IDLE: begin
        pop  = !q_empty;
        busy = 1'b0;
      end
      BACK_ROTATE: begin
        do_step = 1'b1;
      end
      BACK_ACCUM: begin
        do_accum = !out_blocked;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x    <= x_start;
      y    <= '0;
      z    <= $signed({{(Z_W - TURN_W){head.angle[TURN_W-1]}}, head.angle});
      flip <= head.flip;
      last <= head.last;
      iter <= '0;
    end else if (do_step) begin
      iter <= iter + 1'b1;
      if (!z[Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - z_step;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + z_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum   <= '0;
      y_accum   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (do_accum && last) || (out_valid && !out_ready);
      if (do_accum) begin
        if (last) begin
          x_accum <= '0;
          y_accum <= '0;
        end else begin
          x_accum <= x_accum_next;
          y_accum <= y_accum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_accum && last) begin
      pos_x <= sat_pos(x_accum_next);
      pos_y <= sat_pos(y_accum_next);
    end
  end

endmodule

@@ hw/rtl/planar_arm_forward_kinematics_top.sv @@
// top level of the planar arm forward kinematics block
//
//   channel  direction  handshake             payload
//   in       in         in_valid/in_ready     joint_angle, last_joint
//   out      out        out_valid/out_ready   pos_x, pos_y
//   cfg      in         cfg_valid/cfg_ready   link_length
//
// a joint passes the rotation unit's states in order: idle takes the request
// and forms the start vector, rotate runs the CORDIC_STEPS shared shift-add
// iterations, accum accumulates; the front end takes requests back to back
// until the two-entry queue fills. rst is synchronous and clears the angle
// sum, the accumulators and link_length (to 10923); cfg_ready is always high.
// a result held in the output register stalls only the end of the next arm.
module planar_arm_forward_kinematics_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pafk_pkg::ANGLE_W-1:0] joint_angle,
  input  logic                                last_joint,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pafk_pkg::POS_W-1:0]   pos_x,
  output logic signed [pafk_pkg::POS_W-1:0]   pos_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pafk_pkg::LINK_W-1:0]         link_length
);
  import pafk_pkg::*;

`include "planar_arm_forward_kinematics_top_defines.svh"

  logic [LINK_W-1:0] link_len;
  queue_status_t     q_status;
  joint_req_t        push_req;
  joint_req_t        head;
  logic              push;
  logic              pop;
  logic              back_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_len <= LINK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      link_len <= link_length;
    end
  end

  pafk_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .joint_angle (joint_angle),
    .last_joint  (last_joint),
    .q_status    (q_status),
    .push        (push),
    .push_req    (push_req)
  );

  pafk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  pafk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .link_len  (link_len),
    .q_empty   (q_status.empty),
    .head      (head),
    .pop       (pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y)
  );

  // an accepted request is held in the queue until the back end takes it
  `PAFK_ASSERT_NEXT(a_push_kept, in_valid && in_ready, !q_status.empty)
  // an idle back end takes a waiting request at once
  `PAFK_ASSERT_NEXT(a_back_takes, !back_busy && !q_status.empty, back_busy)
  // a result appears only at the end of a rotation
  `PAFK_ASSERT_NOW(a_result_from_back, $rose(out_valid), $past(back_busy))

endmodule

@@ verif/planar_arm_forward_kinematics_top_tb.sv @@
// self-checking testbench for the planar arm forward kinematics block
`timescale 1ns / 1ps

module testbench;
  import pafk_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 80;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN     = 16'sh4000;
  localparam logic signed [ANGLE_W-1:0] NEG_QUARTER_TURN = 16'shC000;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN        = 16'sh8000;
  localparam logic signed [ANGLE_W-1:0] MAX_ANGLE        = 16'sh7FFF;

  localparam logic [LINK_W-1:0] LINK_MAX   = 15'd32767;
  localparam logic [LINK_W-1:0] LINK_RESET_LEN = 15'd10923;

  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint QUARTER_Q32     = 64'sd1073741824;
  localparam longint HALF_Q32        = 64'sd2147483648;
  localparam longint REACH_MAX       = 64'sd8388607;
  localparam longint REACH_MIN       = -64'sd8388608;
  localparam longint TIP_MAX         = 64'sd32767;
  localparam longint TIP_MIN         = -64'sd32768;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } tip_pos_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [ANGLE_W-1:0]  joint_angle;
  logic                       last_joint;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [LINK_W-1:0]          link_length;

  // arctangent of 2^-i in units of 2^-32 turn
  longint atan_q32 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  // predicted arm state
  logic [LINK_W-1:0]  link_len    = LINK_RESET_LEN;
  logic [ANGLE_W-1:0] heading_sum = '0;
  longint             x_reach     = 0;
  longint             y_reach     = 0;
  tip_pos_t           expected_tips [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int joints_sent;
  int arms_closed;
  int tips_checked;
  int link_settings;
  int cycle_count;

  planar_arm_forward_kinematics_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .joint_angle (joint_angle),
    .last_joint  (last_joint),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .link_length (link_length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("planar_arm_forward_kinematics_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one link rotated to the given heading, cos and sin in Q1.14
  function automatic void link_vector(input logic [ANGLE_W-1:0] heading,
                                      input logic [LINK_W-1:0] len,
                                      output longint cx, output longint sy);
    longint z, x, y, dx, dy, step;
    bit     flip;
    z    = longint'($signed(heading)) * 65536;
    flip = 1'b0;
    if (z >= QUARTER_Q32) begin
      z -= HALF_Q32;
      flip = 1'b1;
    end else if (z < -QUARTER_Q32) begin
      z += HALF_Q32;
      flip = 1'b1;
    end
    x = (longint'(len) * CORDIC_GAIN_Q30) >>> 15;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      step = ((atan_q32[i] + 32768) >>> 16) <<< 16;
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= step;
      end else begin
        x += dx;
        y -= dy;
        z += step;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cx = (x + 32768) >>> 16;
    sy = (y + 32768) >>> 16;
  endfunction

  function automatic void take_joint(input logic [ANGLE_W-1:0] angle, input logic last);
    longint   cx, sy;
    tip_pos_t tip;
    heading_sum = heading_sum + angle;
    link_vector(heading_sum, link_len, cx, sy);
    x_reach = clamp(x_reach + cx, REACH_MIN, REACH_MAX);
    y_reach = clamp(y_reach + sy, REACH_MIN, REACH_MAX);
    if (last) begin
      tip.x = 16'(clamp(x_reach, TIP_MIN, TIP_MAX));
      tip.y = 16'(clamp(y_reach, TIP_MIN, TIP_MAX));
      expected_tips.push_back(tip);
      heading_sum = '0;
      x_reach     = 0;
      y_reach     = 0;
      arms_closed++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    tip_pos_t tip;
    if (!rst) begin
      if (out_valid && out_ready) begin
        tips_checked++;
        if (expected_tips.size() == 0) begin
          $error("unexpected end position: pos_x %0d, pos_y %0d", pos_x, pos_y);
          mismatches++;
        end else begin
          tip = expected_tips.pop_front();
          if (pos_x !== tip.x) begin
            $error("pos_x: expected %0d, actual %0d", tip.x, pos_x);
            mismatches++;
          end
          if (pos_y !== tip.y) begin
            $error("pos_y: expected %0d, actual %0d", tip.y, pos_y);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) link_len = link_length;
      if (in_valid && in_ready) take_joint(joint_angle, last_joint);
    end
  end

  task automatic send_joint(input logic signed [ANGLE_W-1:0] angle, input logic last);
    in_valid    <= 1'b1;
    joint_angle <= angle;
    last_joint  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    joints_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
  endtask

  task automatic drain_block();
    @(posedge clk);
    while (expected_tips.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_link_length(input logic [LINK_W-1:0] len);
    cfg_valid   <= 1'b1;
    link_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    link_settings++;
  endtask

  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(9))
      0: return '0;
      1: return QUARTER_TURN;
      2: return NEG_QUARTER_TURN;
      3: return HALF_TURN;
      4: return MAX_ANGLE;
      5: return 16'($urandom_range(32) - 16);
      6: return QUARTER_TURN + 16'($urandom_range(8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LINK_W-1:0] pick_link();
    case ($urandom_range(3))
      0: return '0;
      1: return LINK_MAX;
      default: return 15'($urandom_range(32767));
    endcase
  endfunction

  task automatic run_arm(input int joints);
    for (int j = 1; j <= joints; j++) send_joint(pick_angle(), j == joints);
  endtask

  task automatic test_reset_length();
    send_joint('0, 1'b1);
    send_joint(QUARTER_TURN, 1'b1);
    send_joint(NEG_QUARTER_TURN, 1'b1);
    send_joint(HALF_TURN, 1'b1);
    send_joint(MAX_ANGLE, 1'b1);
    send_joint(16'sd1, 1'b1);
    send_joint(-16'sd1, 1'b1);
    // heading wraps round to zero
    send_joint(MAX_ANGLE, 1'b0);
    send_joint(MAX_ANGLE, 1'b0);
    send_joint(16'sd2, 1'b1);
    end_stream();
  endtask

  task automatic test_link_extremes();
    drain_block();
    set_link_length('0);
    send_joint(16'($urandom), 1'b0);
    send_joint(16'($urandom), 1'b1);
    end_stream();
    drain_block();
    set_link_length(LINK_MAX);
    // three full links overrun the output range in each direction
    send_joint('0, 1'b0);
    send_joint('0, 1'b0);
    send_joint('0, 1'b1);
    send_joint(HALF_TURN, 1'b0);
    send_joint('0, 1'b0);
    send_joint('0, 1'b1);
    send_joint(QUARTER_TURN, 1'b0);
    send_joint('0, 1'b0);
    send_joint('0, 1'b1);
    send_joint(NEG_QUARTER_TURN, 1'b0);
    send_joint('0, 1'b0);
    send_joint('0, 1'b1);
    end_stream();
  endtask

  task automatic test_mid_arm_change();
    drain_block();
    set_link_length(15'd16384);
    send_joint(16'($urandom), 1'b0);
    send_joint(16'($urandom), 1'b0);
    end_stream();
    drain_block();
    set_link_length(15'd5000);
    send_joint(16'($urandom), 1'b0);
    send_joint(16'($urandom), 1'b1);
    end_stream();
  endtask

  task automatic test_accumulator_saturation();
    int d;
    d = 0;
    drain_block();
    set_link_length(LINK_MAX);
    // heading held near half a turn so x runs past the accumulator range
    send_joint(HALF_TURN, 1'b0);
    for (int k = 1; k <= 529; k++) begin
      if (k % 2) d = $urandom_range(300);
      send_joint((k % 2) ? 16'(d) : 16'(-d), k == 529);
    end
    end_stream();
  endtask

  task automatic test_random_arms(input int target);
    int first;
    first = joints_sent;
    while (joints_sent - first < target) begin
      if ($urandom_range(11) == 0) begin
        end_stream();
        drain_block();
        set_link_length(pick_link());
      end
      run_arm(($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6));
    end
    end_stream();
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    joint_angle <= '0;
    last_joint  <= 1'b0;
    cfg_valid   <= 1'b0;
    link_length <= '0;
    send_idle_pct = 7;
    recv_idle_pct = 87;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_length();
    test_link_extremes();
    test_mid_arm_change();
    test_accumulator_saturation();
    drain_block();
    set_link_length(pick_link());
    test_random_arms(30);

    drain_block();
    set_link_length(pick_link());
    send_idle_pct = 87;
    recv_idle_pct = 7;
    test_random_arms(30);

    drain_block();
    set_link_length(pick_link());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_arms(30);

    drain_block();
    $display("ran %0d joints over %0d arms, %0d end positions compared",
             joints_sent, arms_closed, tips_checked);
    $display("%0d link length writes incl. both extremes, a mid-arm change and a saturating arm",
             link_settings);
    if (mismatches == 0) begin
      $display("planar_arm_forward_kinematics_top regression: pass");
    end else begin
      $display("planar_arm_forward_kinematics_top regression: fail");
    end
    $finish;
  end

endmodule
